>>> rtl/s2e_pkg.sv
// shared constants for the symmetric 2x2 eigen decomposition block
// no dependencies; used by the top level and by s2e_frac_div
package s2e_pkg;

  // default width of the matrix entries and eigenvalues
  localparam int DATA_WIDTH_DEF = 32;

  // rotation cos and sin format, signed Q2.30
  localparam int ROT_W    = 32;
  localparam int ROT_FRAC = 30;

  // quotient bits out of the divider: one integer bit plus rounding bit
  localparam int QUO_W = ROT_FRAC + 2;

  // 1.0 in Q2.30
  localparam logic [ROT_W-1:0] ROT_ONE = ROT_W'(1) << ROT_FRAC;

endpackage

>>> rtl/symmetric_2x2_eigen_decompose.sv
// top level of the symmetric 2x2 eigen decomposition pipeline
// uses s2e_pkg, s2e_sumsq, s2e_isqrt_pipe and s2e_frac_div
//
// usage
//   input stream  s_tvalid / s_tready / s_tdata: one symmetric matrix per
//   transaction, entries in two's complement with any fraction scaling
//   (the scale cancels, so the result bits do not depend on it)
//   output stream m_tvalid / m_tready / m_tdata / m_tuser: one result per
//   matrix, in input order; the smaller eigenvalue comes first, cos and sin
//   are Q2.30 and form the unit eigenvector of the smaller eigenvalue
//   m_tuser is the degenerate flag: identity rotation, length was zero
// throughput: one matrix per cycle while the output is not stalled, fully pipelined
// pipeline: the bulk is made of the two bit-serial square root pipelines
//   (DATA_WIDTH+2 and DATA_WIDTH+4 stages) and the 32-stage fraction
//   divider
// reset: rst clears every stage valid bit; the pipeline comes up empty
//   and s_tready is high in the first cycle after reset
// stall: when the output register holds a result that is not taken, the
//   whole pipeline freezes and s_tready drops; nothing is lost or repeated
//   and bubbles still move forward while the output is free
module symmetric_2x2_eigen_decompose #(
  parameter int DATA_WIDTH = s2e_pkg::DATA_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // diag_first, off_diag, diag_second, zero fill
  input  logic [((3 * DATA_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // eigen_low, eigen_high, rot_cos, rot_sin, zero fill
  output logic [((2 * DATA_WIDTH + 2 * s2e_pkg::ROT_W + 7) / 8) * 8 - 1:0] m_tdata,
  // degenerate
  output logic                     m_tuser
);

  localparam int W      = DATA_WIDTH;
  localparam int RW     = s2e_pkg::ROT_W;
  localparam int QW     = s2e_pkg::QUO_W;
  localparam int OUT_TW = ((2 * W + 2 * RW + 7) / 8) * 8;
  localparam int MW     = W + 1;        // magnitude of diff and of 2b
  localparam int EW     = W + 2;        // unsaturated eigenvalues
  localparam int CW     = W + 3;        // signed vector components
  localparam int R1_W   = MW + 1;       // first root
  localparam int R2_W   = CW + 1;       // normalising length

  typedef struct packed {
    logic signed [W-1:0]  a;
    logic signed [W-1:0]  b;
    logic signed [W-1:0]  d;
    logic signed [W:0]    trace;
    logic                 diff_neg;
  } front_t;

  typedef struct packed {
    logic signed [EW-1:0] e0;
    logic signed [EW-1:0] e1;
    logic                 c_neg;
    logic                 s_neg;
    logic [CW-1:0]        mc;
    logic [CW-1:0]        ms;
  } vec_t;

  typedef struct packed {
    logic signed [EW-1:0] e0;
    logic signed [EW-1:0] e1;
    logic                 c_neg;
    logic                 s_neg;
    logic                 len_zero;
  } tail_t;

  // global advance: move whenever the output register is free or drained
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // ---------------- front stage: trace, diff, magnitudes ----------------
  logic signed [W-1:0] in_a, in_b, in_d;
  logic signed [W:0]   trace_c, diff_c;
  logic [MW-1:0]       mdiff_c, mb_c, twob_c;

  assign in_a = s_tdata[W-1:0];
  assign in_b = s_tdata[2*W-1:W];
  assign in_d = s_tdata[3*W-1:2*W];

  always_comb begin
    trace_c = {in_a[W-1], in_a} + {in_d[W-1], in_d};
    diff_c  = {in_a[W-1], in_a} - {in_d[W-1], in_d};
    mdiff_c = diff_c[W] ? MW'(-diff_c) : MW'(diff_c);
    mb_c    = in_b[W-1] ? MW'(-{in_b[W-1], in_b}) : MW'({in_b[W-1], in_b});
    twob_c  = {mb_c[MW-2:0], 1'b0};
  end

  logic          f_valid;
  front_t        f_side;
  logic [MW-1:0] f_mdiff, f_twob;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_side.a        <= in_a;
      f_side.b        <= in_b;
      f_side.d        <= in_d;
      f_side.trace    <= trace_c;
      f_side.diff_neg <= diff_c[W];
      f_mdiff         <= mdiff_c;
      f_twob          <= twob_c;
    end
  end

  // ---------------- discriminant and its square root ----------------
  logic              q1_valid;
  logic [2*MW+1:0]   q1_sum;
  front_t            q1_side;

  s2e_sumsq #(.IN_W(MW), .SIDE_W($bits(front_t))) u_disc (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (f_valid),
    .x        (f_mdiff),
    .y        (f_twob),
    .in_side  (f_side),
    .out_valid(q1_valid),
    .sum      (q1_sum),
    .out_side (q1_side)
  );

  logic              r1_valid;
  logic [R1_W-1:0]   r1_root;
  front_t            r1_side;

  s2e_isqrt_pipe #(.RAD_W(2 * MW + 2), .SIDE_W($bits(front_t))) u_root1 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (q1_valid),
    .radicand (q1_sum),
    .in_side  (q1_side),
    .out_valid(r1_valid),
    .root     (r1_root),
    .out_side (r1_side)
  );

  // ---------------- eigenvalues and eigenvector components ----------------
  logic signed [W+3:0]  tr_x, rt_x, lo_sum, hi_sum;
  logic signed [EW-1:0] e0_c, e1_c;
  logic signed [CW-1:0] c_c, s_c;
  vec_t                 vec_c;

  always_comb begin
    tr_x   = (W + 4)'(r1_side.trace);
    rt_x   = $signed({2'b00, r1_root});
    lo_sum = tr_x - rt_x;
    hi_sum = tr_x + rt_x;
    // halving with floor, then trimmed to the eigenvalue width
    e0_c   = lo_sum[EW:1];
    e1_c   = hi_sum[EW:1];
    if (!r1_side.diff_neg) begin
      c_c = CW'(r1_side.b);
      s_c = CW'(e0_c) - CW'(r1_side.a);
    end else begin
      c_c = CW'(e0_c) - CW'(r1_side.d);
      s_c = CW'(r1_side.b);
    end
    vec_c.e0    = e0_c;
    vec_c.e1    = e1_c;
    vec_c.c_neg = c_c[CW-1];
    vec_c.s_neg = s_c[CW-1];
    vec_c.mc    = c_c[CW-1] ? CW'(-c_c) : CW'(c_c);
    vec_c.ms    = s_c[CW-1] ? CW'(-s_c) : CW'(s_c);
  end

  logic v_valid;
  vec_t v_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_valid <= 1'b0;
    end else if (en) begin
      v_valid <= r1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_side <= vec_c;
    end
  end

  // ---------------- vector length ----------------
  logic              q2_valid;
  logic [2*CW+1:0]   q2_sum;
  vec_t              q2_side;

  s2e_sumsq #(.IN_W(CW), .SIDE_W($bits(vec_t))) u_lensq (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v_valid),
    .x        (v_side.mc),
    .y        (v_side.ms),
    .in_side  (v_side),
    .out_valid(q2_valid),
    .sum      (q2_sum),
    .out_side (q2_side)
  );

  logic              r2_valid;
  logic [R2_W-1:0]   r2_len;
  vec_t              r2_side;

  s2e_isqrt_pipe #(.RAD_W(2 * CW + 2), .SIDE_W($bits(vec_t))) u_root2 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (q2_valid),
    .radicand (q2_sum),
    .in_side  (q2_side),
    .out_valid(r2_valid),
    .root     (r2_len),
    .out_side (r2_side)
  );

  // ---------------- normalisation ----------------
  tail_t tail_c;

  always_comb begin
    tail_c.e0       = r2_side.e0;
    tail_c.e1       = r2_side.e1;
    tail_c.c_neg    = r2_side.c_neg;
    tail_c.s_neg    = r2_side.s_neg;
    tail_c.len_zero = (r2_len == '0);
  end

  logic          d_valid;
  logic [QW-1:0] d_qc, d_qs;
  tail_t         d_side;

  s2e_frac_div #(.DEN_W(R2_W), .Q_W(QW), .SIDE_W($bits(tail_t))) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (r2_valid),
    .num_c    (R2_W'(r2_side.mc)),
    .num_s    (R2_W'(r2_side.ms)),
    .den      (r2_len),
    .in_side  (tail_c),
    .out_valid(d_valid),
    .quo_c    (d_qc),
    .quo_s    (d_qs),
    .out_side (d_side)
  );

  // ---------------- rounding, sign, saturation, output register ----------------
  function automatic logic [W-1:0] sat_eig(input logic signed [EW-1:0] e);
    logic [W-1:0] r;
    if (e[EW-1:W-1] == '0 || e[EW-1:W-1] == '1) begin
      r = e[W-1:0];
    end else if (e[EW-1]) begin
      r = {1'b1, {(W - 1){1'b0}}};
    end else begin
      r = {1'b0, {(W - 1){1'b1}}};
    end
    return r;
  endfunction

  logic [QW:0]    rc_sum, rs_sum;
  logic [RW-1:0]  mag_c, mag_s, cos_c, sin_c;

  always_comb begin
    // round half up to Q2.30, sign applied afterwards
    rc_sum = {1'b0, d_qc} + (QW + 1)'(1);
    rs_sum = {1'b0, d_qs} + (QW + 1)'(1);
    mag_c  = RW'(rc_sum[QW:1]);
    mag_s  = RW'(rs_sum[QW:1]);
    if (d_side.len_zero) begin
      cos_c = s2e_pkg::ROT_ONE;
      sin_c = '0;
    end else begin
      cos_c = d_side.c_neg ? -mag_c : mag_c;
      sin_c = d_side.s_neg ? -mag_s : mag_s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= OUT_TW'({sin_c, cos_c, sat_eig(d_side.e1), sat_eig(d_side.e0)});
      m_tuser <= d_side.len_zero;
    end
  end

endmodule

>>> rtl/s2e_sumsq.sv
// two-stage sum of squares of two unsigned magnitudes, with sideband
// depends on nothing outside this file
module s2e_sumsq #(
  parameter int IN_W   = 33,
  parameter int SIDE_W = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [IN_W-1:0]       x,
  input  logic [IN_W-1:0]       y,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_valid,
  output logic [2*IN_W+1:0]     sum,
  output logic [SIDE_W-1:0]     out_side
);

  logic                  valid_a;
  logic [2*IN_W-1:0]     sqx;
  logic [2*IN_W-1:0]     sqy;
  logic [SIDE_W-1:0]     side_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      valid_a   <= in_valid;
      out_valid <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx      <= x * x;
      sqy      <= y * y;
      side_a   <= in_side;
      sum      <= {2'b00, sqx} + {2'b00, sqy};
      out_side <= side_a;
    end
  end

endmodule

>>> rtl/s2e_isqrt_pipe.sv
// pipelined integer square root, one root bit per stage, with sideband
// depends on nothing outside this file
module s2e_isqrt_pipe #(
  parameter int RAD_W  = 68,
  parameter int SIDE_W = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [RAD_W-1:0]      radicand,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_valid,
  output logic [RAD_W/2-1:0]    root,
  output logic [SIDE_W-1:0]     out_side
);

  localparam int RT_W = RAD_W / 2;
  localparam int RM_W = RT_W + 3;

  logic [RT_W:0]         vld;
  logic [RAD_W-1:0]      rad_q  [RT_W+1];
  logic [RM_W-1:0]       rem_q  [RT_W+1];
  logic [RT_W-1:0]       root_q [RT_W+1];
  logic [SIDE_W-1:0]     side_q [RT_W+1];

  assign vld[0]    = in_valid;
  assign rad_q[0]  = radicand;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign side_q[0] = in_side;

  for (genvar i = 0; i < RT_W; i++) begin : g_stage
    logic [RM_W-1:0] cur;
    logic [RM_W-1:0] trial;
    logic            ge;

    always_comb begin
      cur   = {rem_q[i][RM_W-3:0], rad_q[i][RAD_W-1 -: 2]};
      trial = {1'b0, root_q[i], 2'b01};
      ge    = (cur >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[i+1]  <= {rad_q[i][RAD_W-3:0], 2'b00};
        rem_q[i+1]  <= ge ? (cur - trial) : cur;
        root_q[i+1] <= {root_q[i][RT_W-2:0], ge};
        side_q[i+1] <= side_q[i];
      end
    end
  end

  assign out_valid = vld[RT_W];
  assign root      = root_q[RT_W];
  assign out_side  = side_q[RT_W];

endmodule

>>> rtl/s2e_frac_div.sv
// pipelined restoring fraction divider, two numerator lanes over one
// denominator, one quotient bit per stage; uses s2e_pkg
module s2e_frac_div #(
  parameter int DEN_W  = 36,
  parameter int Q_W    = s2e_pkg::QUO_W,
  parameter int SIDE_W = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [DEN_W-1:0]      num_c,
  input  logic [DEN_W-1:0]      num_s,
  input  logic [DEN_W-1:0]      den,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_valid,
  output logic [Q_W-1:0]        quo_c,
  output logic [Q_W-1:0]        quo_s,
  output logic [SIDE_W-1:0]     out_side
);

  logic [Q_W:0]          vld;
  logic [DEN_W-1:0]      den_q  [Q_W+1];
  logic [DEN_W-1:0]      rc_q   [Q_W+1];
  logic [DEN_W-1:0]      rs_q   [Q_W+1];
  logic [Q_W-1:0]        qc_q   [Q_W+1];
  logic [Q_W-1:0]        qs_q   [Q_W+1];
  logic [SIDE_W-1:0]     side_q [Q_W+1];

  assign vld[0]    = in_valid;
  assign den_q[0]  = den;
  assign rc_q[0]   = num_c;
  assign rs_q[0]   = num_s;
  assign qc_q[0]   = '0;
  assign qs_q[0]   = '0;
  assign side_q[0] = in_side;

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [DEN_W:0] cand_c;
    logic [DEN_W:0] cand_s;
    logic [DEN_W:0] den_x;
    logic           ge_c;
    logic           ge_s;

    // first step takes the integer bit, later steps shift the remainder
    always_comb begin
      den_x = {1'b0, den_q[k]};
      if (k == 0) begin
        cand_c = {1'b0, rc_q[k]};
        cand_s = {1'b0, rs_q[k]};
      end else begin
        cand_c = {rc_q[k], 1'b0};
        cand_s = {rs_q[k], 1'b0};
      end
      ge_c = (cand_c >= den_x);
      ge_s = (cand_s >= den_x);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_q[k+1]  <= den_q[k];
        rc_q[k+1]   <= ge_c ? DEN_W'(cand_c - den_x) : DEN_W'(cand_c);
        rs_q[k+1]   <= ge_s ? DEN_W'(cand_s - den_x) : DEN_W'(cand_s);
        qc_q[k+1]   <= {qc_q[k][Q_W-2:0], ge_c};
        qs_q[k+1]   <= {qs_q[k][Q_W-2:0], ge_s};
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign out_valid = vld[Q_W];
  assign quo_c     = qc_q[Q_W];
  assign quo_s     = qs_q[Q_W];
  assign out_side  = side_q[Q_W];

endmodule
